### design/lts_pkg.sv
// lts_pkg: shared constants, codes and types of the lifo stack block
// no dependencies; used by every module of the block

package lts_pkg;

	localparam int STACK_DEPTH    = 1024;
	localparam int WORD_BITS      = 32;
	localparam int MAX_TOP        = 64;
	localparam int TOP_COUNT_BITS = 7;
	localparam int FILL_BITS      = $clog2(STACK_DEPTH + 1);
	localparam int IDX_BITS       = $clog2(MAX_TOP);
	localparam int REMAIN_BITS    = $clog2(MAX_TOP + 1);

	// command codes
	localparam logic [1:0] CMD_PUSH  = 2'd0;
	localparam logic [1:0] CMD_POP   = 2'd1;
	localparam logic [1:0] CMD_PEEK  = 2'd2;
	localparam logic [1:0] CMD_MULTI = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_FROM_UP,
		CELL_FROM_DOWN
	} cell_op_t;

	typedef enum logic [1:0] {
		SRC_NONE,
		SRC_STACK_TOP,
		SRC_READ_TOP
	} emit_src_t;

	typedef enum logic {
		ST_IDLE,
		ST_MULTI
	} state_t;

	typedef struct packed {
		cell_op_t   stack_op;
		cell_op_t   read_op;
		logic       emit;
		emit_src_t  emit_src;
		logic       emit_valid;
		logic [1:0] emit_status;
		logic       emit_last;
		logic       in_stall;
	} ctrl_t;

endpackage

### design/lts_cell.sv
// lts_cell: one word cell of a shift chain, takes a neighbor's word or holds
// depends on lts_pkg

module lts_cell (
	input  logic                          clk,
	input  lts_pkg::cell_op_t             op,
	input  logic [lts_pkg::WORD_BITS-1:0] up_word,
	input  logic [lts_pkg::WORD_BITS-1:0] down_word,
	output logic [lts_pkg::WORD_BITS-1:0] word
);

	logic [lts_pkg::WORD_BITS-1:0] word_q;

	always_ff @(posedge clk) begin
		case (op)
			lts_pkg::CELL_FROM_UP:   word_q <= up_word;
			lts_pkg::CELL_FROM_DOWN: word_q <= down_word;
			default:                 word_q <= word_q;
		endcase
	end

	assign word = word_q;

endmodule

### design/lts_ctrl.sv
// lts_ctrl: command sequencer, fill count and multi-top read counters
// depends on lts_pkg

module lts_ctrl (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic [1:0]                         cmd,
	input  logic [lts_pkg::TOP_COUNT_BITS-1:0] top_count,
	input  logic                               out_free,
	output lts_pkg::ctrl_t                     ctrl
);

	lts_pkg::state_t                    state_q, state_d;
	logic [lts_pkg::FILL_BITS-1:0]      fill_q, fill_d;
	logic [lts_pkg::REMAIN_BITS-1:0]    remain_q, remain_d;
	logic [lts_pkg::IDX_BITS-1:0]       idx_q, idx_d;
	logic [lts_pkg::REMAIN_BITS-1:0]    n_sat;
	logic                               accept;
	logic                               is_full;
	logic                               is_empty;

	assign is_full  = (fill_q == lts_pkg::FILL_BITS'(lts_pkg::STACK_DEPTH));
	assign is_empty = (fill_q == '0);
	assign accept   = in_valid && out_free && (state_q == lts_pkg::ST_IDLE);

	// saturate the requested count to the longest burst
	always_comb begin
		if (top_count > lts_pkg::TOP_COUNT_BITS'(lts_pkg::MAX_TOP)) begin
			n_sat = lts_pkg::REMAIN_BITS'(lts_pkg::MAX_TOP);
		end else begin
			n_sat = lts_pkg::REMAIN_BITS'(top_count);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lts_pkg::ST_IDLE: begin
				if (accept && cmd == lts_pkg::CMD_MULTI && n_sat != '0) begin
					state_d = lts_pkg::ST_MULTI;
				end
			end
			lts_pkg::ST_MULTI: begin
				if (out_free && remain_q == lts_pkg::REMAIN_BITS'(1)) begin
					state_d = lts_pkg::ST_IDLE;
				end
			end
			default: state_d = lts_pkg::ST_IDLE;
		endcase
	end

	// outputs and counters
	always_comb begin
		ctrl          = '0;
		ctrl.stack_op = lts_pkg::CELL_HOLD;
		ctrl.read_op  = lts_pkg::CELL_HOLD;
		ctrl.emit_src = lts_pkg::SRC_NONE;
		fill_d        = fill_q;
		remain_d      = remain_q;
		idx_d         = idx_q;
		case (state_q)
			lts_pkg::ST_IDLE: begin
				ctrl.in_stall = !out_free;
				if (accept) begin
					case (cmd)
						lts_pkg::CMD_PUSH: begin
							ctrl.emit      = 1'b1;
							ctrl.emit_last = 1'b1;
							if (is_full) begin
								ctrl.emit_status = lts_pkg::ST_FULL;
							end else begin
								ctrl.stack_op = lts_pkg::CELL_FROM_UP;
								fill_d        = fill_q + 1'b1;
							end
						end
						lts_pkg::CMD_POP, lts_pkg::CMD_PEEK: begin
							ctrl.emit      = 1'b1;
							ctrl.emit_last = 1'b1;
							if (is_empty) begin
								ctrl.emit_status = lts_pkg::ST_EMPTY;
							end else begin
								ctrl.emit_src   = lts_pkg::SRC_STACK_TOP;
								ctrl.emit_valid = 1'b1;
								if (cmd == lts_pkg::CMD_POP) begin
									ctrl.stack_op = lts_pkg::CELL_FROM_DOWN;
									fill_d        = fill_q - 1'b1;
								end
							end
						end
						default: begin
							// snapshot the top entries into the read chain
							if (n_sat != '0) begin
								ctrl.read_op = lts_pkg::CELL_FROM_UP;
								remain_d     = n_sat;
								idx_d        = '0;
							end
						end
					endcase
				end
			end
			lts_pkg::ST_MULTI: begin
				ctrl.in_stall = 1'b1;
				if (out_free) begin
					ctrl.emit       = 1'b1;
					ctrl.emit_src   = lts_pkg::SRC_READ_TOP;
					ctrl.emit_valid = (lts_pkg::FILL_BITS'(idx_q) < fill_q);
					ctrl.emit_last  = (remain_q == lts_pkg::REMAIN_BITS'(1));
					ctrl.read_op    = lts_pkg::CELL_FROM_DOWN;
					remain_d        = remain_q - 1'b1;
					idx_d           = idx_q + 1'b1;
				end
			end
			default: ctrl.in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lts_pkg::ST_IDLE;
			fill_q   <= '0;
			remain_q <= '0;
			idx_q    <= '0;
		end else begin
			state_q  <= state_d;
			fill_q   <= fill_d;
			remain_q <= remain_d;
			idx_q    <= idx_d;
		end
	end

endmodule

### design/lifo_stack_with_multi_top_read_unit.sv
// lifo_stack_with_multi_top_read_unit: top level of the lifo stack block
// depends on lts_pkg, lts_cell, lts_ctrl
//
//   channel   direction   handshake               payload
//   in        to block    in_valid / in_stall     cmd, push_value, top_count
//   out       from block  out_valid / out_stall   data_word, data_valid, status, last_result
//
// push, pop and peek can follow back to back while the output register drains;
// multi-top with n entries first snapshots the top entries into the read chain
// and then gives n results in turn, paced by the single output register.
// reset clears the fill count, the sequencer and the output valid; the cells
// keep whatever they hold, and only entries below the fill count are ever read.
// a stalled output holds its item; the input stalls with it.

module lifo_stack_with_multi_top_read_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         cmd,
	input  logic [lts_pkg::WORD_BITS-1:0]      push_value,
	input  logic [lts_pkg::TOP_COUNT_BITS-1:0] top_count,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [lts_pkg::WORD_BITS-1:0]      data_word,
	output logic                               data_valid,
	output logic [1:0]                         status,
	output logic                               last_result
);

	lts_pkg::ctrl_t ctrl;

	// stack chain: cell 0 is the top, a push shifts everything one cell down
	logic [lts_pkg::WORD_BITS-1:0] stack_word [lts_pkg::STACK_DEPTH];
	// read chain: snapshot of the top entries, shifted up one per result
	logic [lts_pkg::WORD_BITS-1:0] read_word [lts_pkg::MAX_TOP];

	logic                          out_valid_q;
	logic [lts_pkg::WORD_BITS-1:0] data_word_q;
	logic                          data_valid_q;
	logic [1:0]                    status_q;
	logic                          last_result_q;
	logic                          out_free;
	logic [lts_pkg::WORD_BITS-1:0] emit_word;

	// the output register can take a new item when empty or being drained
	assign out_free = !out_valid_q || !out_stall;

	lts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.cmd       (cmd),
		.top_count (top_count),
		.out_free  (out_free),
		.ctrl      (ctrl)
	);

	genvar gi;
	generate
		for (gi = 0; gi < lts_pkg::STACK_DEPTH; gi++) begin : g_stack
			logic [lts_pkg::WORD_BITS-1:0] up_w;
			logic [lts_pkg::WORD_BITS-1:0] down_w;
			if (gi == 0) begin : g_top
				assign up_w = push_value;
			end else begin : g_mid
				assign up_w = stack_word[gi-1];
			end
			if (gi == lts_pkg::STACK_DEPTH - 1) begin : g_bot
				assign down_w = '0;
			end else begin : g_inner
				assign down_w = stack_word[gi+1];
			end
			lts_cell u_cell (
				.clk       (clk),
				.op        (ctrl.stack_op),
				.up_word   (up_w),
				.down_word (down_w),
				.word      (stack_word[gi])
			);
		end

		for (gi = 0; gi < lts_pkg::MAX_TOP; gi++) begin : g_read
			logic [lts_pkg::WORD_BITS-1:0] load_w;
			logic [lts_pkg::WORD_BITS-1:0] next_w;
			// positions past the depth load zero, they are never valid
			if (gi < lts_pkg::STACK_DEPTH) begin : g_tap
				assign load_w = stack_word[gi];
			end else begin : g_none
				assign load_w = '0;
			end
			if (gi == lts_pkg::MAX_TOP - 1) begin : g_end
				assign next_w = '0;
			end else begin : g_link
				assign next_w = read_word[gi+1];
			end
			lts_cell u_cell (
				.clk       (clk),
				.op        (ctrl.read_op),
				.up_word   (load_w),
				.down_word (next_w),
				.word      (read_word[gi])
			);
		end
	endgenerate

	// word shown with a result, zero whenever it is not a stored entry
	always_comb begin
		emit_word = '0;
		if (ctrl.emit_valid) begin
			case (ctrl.emit_src)
				lts_pkg::SRC_STACK_TOP: emit_word = stack_word[0];
				lts_pkg::SRC_READ_TOP:  emit_word = read_word[0];
				default:                emit_word = '0;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			data_word_q   <= emit_word;
			data_valid_q  <= ctrl.emit_valid;
			status_q      <= ctrl.emit_status;
			last_result_q <= ctrl.emit_last;
		end
	end

	assign in_stall    = ctrl.in_stall;
	assign out_valid   = out_valid_q;
	assign data_word   = data_word_q;
	assign data_valid  = data_valid_q;
	assign status      = status_q;
	assign last_result = last_result_q;

endmodule

### design/lts_checker.sv
// lts_checker: port-level assertions for the lifo stack block, with its bind
// depends on lts_pkg and lifo_stack_with_multi_top_read_unit

module lts_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [lts_pkg::WORD_BITS-1:0] data_word,
	input logic                          data_valid,
	input logic [1:0]                    status,
	input logic                          last_result
);

	// a stalled item stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out item dropped under stall");

	// a stalled item keeps its word
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(data_word))
		else $error("out word changed under stall");

	// a blocked output backs up into the input
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while output is stalled");

	// no stored entry means a zero word
	a_null_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !data_valid |-> data_word == '0)
		else $error("nonzero word on an invalid result");

	// full or empty status only on a single, dataless result
	a_status_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != lts_pkg::ST_OK |-> !data_valid && last_result)
		else $error("error status on a data or non-final result");

endmodule

bind lifo_stack_with_multi_top_read_unit lts_checker u_lts_checker (.*);

### test/tb_lifo_stack_with_multi_top_read_unit.sv
// tb_lifo_stack_with_multi_top_read_unit: self-checking testbench of the lifo stack block
// depends on lts_pkg and lifo_stack_with_multi_top_read_unit; a local stack copy
// predicts every result, which is checked in order against the output channel
`timescale 1ns / 1ps

module tb_lifo_stack_with_multi_top_read_unit;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TAIL_CYCLES    = 100;
	localparam int SHOWN_ERRORS   = 10;

	// traffic shapes, carried by each queued item
	typedef enum logic [1:0] {
		TRAFFIC_FREE,
		TRAFFIC_SEND_IDLE,
		TRAFFIC_RECV_STALL,
		TRAFFIC_BOTH
	} traffic_t;

	typedef struct {
		logic [1:0]                         op;
		logic [lts_pkg::WORD_BITS-1:0]      word;
		logic [lts_pkg::TOP_COUNT_BITS-1:0] count;
		traffic_t                           traffic;
		bit                                 hold_for_drain;
	} stack_cmd_t;

	typedef struct {
		logic [lts_pkg::WORD_BITS-1:0] word;
		logic                          valid;
		logic [1:0]                    stat;
		logic                          last;
	} stack_result_t;

	logic                               clk;
	logic                               arst_n      = 1'b0;
	logic                               in_valid    = 1'b0;
	logic                               in_stall;
	logic [1:0]                         cmd         = lts_pkg::CMD_PUSH;
	logic [lts_pkg::WORD_BITS-1:0]      push_value  = '0;
	logic [lts_pkg::TOP_COUNT_BITS-1:0] top_count   = '0;
	logic                               out_valid;
	logic                               out_stall   = 1'b0;
	logic [lts_pkg::WORD_BITS-1:0]      data_word;
	logic                               data_valid;
	logic [1:0]                         status;
	logic                               last_result;

	// local copy of the stack
	logic [lts_pkg::WORD_BITS-1:0] stack_copy [lts_pkg::STACK_DEPTH];
	int                            stack_fill = 0;

	stack_cmd_t    pending_cmds [$];
	stack_result_t expected_results [$];

	traffic_t traffic_mode   = TRAFFIC_FREE;
	int       idle_cycles    = 0;
	int       mismatch_count = 0;
	int       cmds_accepted  = 0;
	int       results_seen   = 0;
	int       full_refusals  = 0;
	int       multi_reads    = 0;
	int       peak_fill      = 0;

	lifo_stack_with_multi_top_read_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.push_value  (push_value),
		.top_count   (top_count),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.data_word   (data_word),
		.data_valid  (data_valid),
		.status      (status),
		.last_result (last_result)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic stack_result_t make_result(logic [lts_pkg::WORD_BITS-1:0] w, logic v,
			logic [1:0] s, logic l);
		stack_result_t r;
		r.word  = w;
		r.valid = v;
		r.stat  = s;
		r.last  = l;
		return r;
	endfunction

	// apply one command to the stack copy and queue what it must produce
	task automatic predict_stack(stack_cmd_t c);
		int n;
		n = c.count;
		case (c.op)
			lts_pkg::CMD_PUSH: begin
				if (stack_fill >= lts_pkg::STACK_DEPTH) begin
					// full stack: refused, nothing stored
					expected_results.push_back(make_result('0, 1'b0, lts_pkg::ST_FULL,
						1'b1));
					full_refusals++;
				end else begin
					stack_copy[stack_fill] = c.word;
					stack_fill++;
					expected_results.push_back(make_result('0, 1'b0, lts_pkg::ST_OK, 1'b1));
				end
			end
			lts_pkg::CMD_POP, lts_pkg::CMD_PEEK: begin
				if (stack_fill == 0) begin
					expected_results.push_back(make_result('0, 1'b0, lts_pkg::ST_EMPTY,
						1'b1));
				end else begin
					expected_results.push_back(make_result(stack_copy[stack_fill-1], 1'b1,
						lts_pkg::ST_OK, 1'b1));
					if (c.op == lts_pkg::CMD_POP)
						stack_fill--;
				end
			end
			default: begin
				// multi-top: saturate the count, topmost first, null below the bottom
				if (n > lts_pkg::MAX_TOP)
					n = lts_pkg::MAX_TOP;
				multi_reads++;
				for (int i = 0; i < n; i++) begin
					if (i < stack_fill)
						expected_results.push_back(make_result(stack_copy[stack_fill-1-i],
							1'b1, lts_pkg::ST_OK, i == n - 1));
					else
						expected_results.push_back(make_result('0, 1'b0, lts_pkg::ST_OK,
							i == n - 1));
				end
			end
		endcase
		if (stack_fill > peak_fill)
			peak_fill = stack_fill;
	endtask

	task automatic queue_cmd(logic [1:0] op, logic [lts_pkg::WORD_BITS-1:0] w,
			logic [lts_pkg::TOP_COUNT_BITS-1:0] n, traffic_t t, bit hold);
		stack_cmd_t c;
		c.op             = op;
		c.word           = w;
		c.count          = n;
		c.traffic        = t;
		c.hold_for_drain = hold;
		pending_cmds.push_back(c);
	endtask

	function automatic bit roll(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// driver: presents queued items, predicts each one as it is accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin : drive
			bit         taken;
			bit         go;
			bit         idle;
			stack_cmd_t c;
			taken = in_valid && !in_stall;
			if (taken) begin
				predict_stack('{cmd, push_value, top_count, traffic_mode, 1'b0});
				cmds_accepted++;
			end
			if (!in_valid || taken) begin
				idle = (traffic_mode == TRAFFIC_SEND_IDLE) ? roll(48) :
					(traffic_mode == TRAFFIC_BOTH) ? roll(9) : 1'b0;
				go = pending_cmds.size() != 0 && !idle;
				// pressure point: hold off until every result has drained
				if (go && pending_cmds[0].hold_for_drain && expected_results.size() != 0)
					go = 1'b0;
				if (go) begin
					c = pending_cmds.pop_front();
					traffic_mode <= c.traffic;
					cmd          <= c.op;
					push_value   <= c.word;
					top_count    <= c.count;
					in_valid     <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern follows the traffic shape of the current item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			case (traffic_mode)
				TRAFFIC_RECV_STALL: out_stall <= roll(48);
				TRAFFIC_BOTH:       out_stall <= roll(9);
				default:            out_stall <= 1'b0;
			endcase
		end
	end

	// monitor: every accepted result against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_seen <= 0;
		end else if (out_valid && !out_stall) begin : check
			stack_result_t e;
			results_seen <= results_seen + 1;
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= SHOWN_ERRORS)
					$display("[%0t] unexpected result: word %h valid %b status %0d last %b",
						$realtime, data_word, data_valid, status, last_result);
			end else begin
				e = expected_results.pop_front();
				if (data_word !== e.word || data_valid !== e.valid || status !== e.stat ||
						last_result !== e.last) begin
					mismatch_count++;
					if (mismatch_count <= SHOWN_ERRORS)
						$display("[%0t] mismatch: expected word %h valid %b status %0d last %b,",
							$realtime, e.word, e.valid, e.stat, e.last,
							" got word %h valid %b status %0d last %b",
							data_word, data_valid, status, last_result);
				end
			end
		end
	end

	// watchdog: cycles with no handshake on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin : stimulus
		logic [1:0] op;
		int         pick;
		int         n;
		traffic_t   shape;

		// directed: empty stack corner cases first
		queue_cmd(lts_pkg::CMD_POP,   32'h1234_5678, 7'd0,   TRAFFIC_FREE, 1'b0);
		queue_cmd(lts_pkg::CMD_PEEK,  32'h0,         7'd127, TRAFFIC_FREE, 1'b0);
		queue_cmd(lts_pkg::CMD_MULTI, 32'h0,         7'd3,   TRAFFIC_FREE, 1'b0);
		queue_cmd(lts_pkg::CMD_MULTI, 32'hffff_ffff, 7'd0,   TRAFFIC_FREE, 1'b0);
		// data extremes and alternating patterns
		queue_cmd(lts_pkg::CMD_PUSH,  32'h0000_0000, 7'd127, TRAFFIC_FREE, 1'b0);
		queue_cmd(lts_pkg::CMD_PUSH,  32'hffff_ffff, 7'd0,   TRAFFIC_FREE, 1'b0);
		queue_cmd(lts_pkg::CMD_PUSH,  32'ha5a5_a5a5, 7'd64,  TRAFFIC_FREE, 1'b0);
		queue_cmd(lts_pkg::CMD_PUSH,  32'h5a5a_5a5a, 7'd1,   TRAFFIC_FREE, 1'b0);
		queue_cmd(lts_pkg::CMD_PEEK,  32'h0,         7'd0,   TRAFFIC_FREE, 1'b0);
		// multi-top exact depth, past the bottom, single entry
		queue_cmd(lts_pkg::CMD_MULTI, 32'h0,         7'd4,   TRAFFIC_FREE, 1'b0);
		queue_cmd(lts_pkg::CMD_MULTI, 32'h0,         7'd6,   TRAFFIC_FREE, 1'b0);
		queue_cmd(lts_pkg::CMD_MULTI, 32'h0,         7'd1,   TRAFFIC_FREE, 1'b0);
		queue_cmd(lts_pkg::CMD_POP,   32'hffff_ffff, 7'd127, TRAFFIC_FREE, 1'b0);
		queue_cmd(lts_pkg::CMD_MULTI, 32'h0,         7'd0,   TRAFFIC_FREE, 1'b0);
		queue_cmd(lts_pkg::CMD_POP,   32'h0,         7'd0,   TRAFFIC_FREE, 1'b0);
		// saturating counts
		queue_cmd(lts_pkg::CMD_MULTI, 32'h0,         7'd127, TRAFFIC_FREE, 1'b0);
		queue_cmd(lts_pkg::CMD_MULTI, 32'h0,         7'd64,  TRAFFIC_FREE, 1'b0);
		queue_cmd(lts_pkg::CMD_MULTI, 32'h0,         7'd65,  TRAFFIC_FREE, 1'b0);
		queue_cmd(lts_pkg::CMD_POP,   32'h0,         7'd0,   TRAFFIC_FREE, 1'b0);
		queue_cmd(lts_pkg::CMD_POP,   32'h0,         7'd0,   TRAFFIC_FREE, 1'b0);
		queue_cmd(lts_pkg::CMD_POP,   32'h0,         7'd0,   TRAFFIC_FREE, 1'b0);

		// pause for a full drain, then a long multi-top under receiver stalls
		queue_cmd(lts_pkg::CMD_PUSH,  32'hdead_beef, 7'd0,   TRAFFIC_FREE, 1'b1);
		queue_cmd(lts_pkg::CMD_PUSH,  32'hffff_ffff, 7'd127, TRAFFIC_FREE, 1'b0);
		queue_cmd(lts_pkg::CMD_PEEK,  32'h0,         7'd0,   TRAFFIC_FREE, 1'b0);
		queue_cmd(lts_pkg::CMD_MULTI, 32'h0,         7'd127, TRAFFIC_RECV_STALL, 1'b0);
		queue_cmd(lts_pkg::CMD_POP,   32'h0,         7'd0,   TRAFFIC_FREE, 1'b0);
		queue_cmd(lts_pkg::CMD_PUSH,  32'h0bad_cafe, 7'd0,   TRAFFIC_FREE, 1'b0);
		queue_cmd(lts_pkg::CMD_PUSH,  32'h0000_0001, 7'd0,   TRAFFIC_FREE, 1'b0);
		// drain the stack to empty
		queue_cmd(lts_pkg::CMD_POP,   32'h0,         7'd0,   TRAFFIC_FREE, 1'b1);
		queue_cmd(lts_pkg::CMD_POP,   32'h0,         7'd0,   TRAFFIC_FREE, 1'b0);
		queue_cmd(lts_pkg::CMD_POP,   32'h0,         7'd0,   TRAFFIC_FREE, 1'b0);

		// random mix, one traffic shape per quarter
		for (int i = 0; i < 100; i++) begin
			shape = traffic_t'(i / 25);
			pick  = $urandom_range(0, 99);
			op    = (pick < 40) ? lts_pkg::CMD_PUSH : (pick < 65) ? lts_pkg::CMD_POP :
				(pick < 75) ? lts_pkg::CMD_PEEK : lts_pkg::CMD_MULTI;
			if (op == lts_pkg::CMD_MULTI)
				n = roll(15) ? $urandom_range(60, 127) : $urandom_range(0, 12);
			else
				n = $urandom_range(0, 127);
			queue_cmd(op, roll(10) ? (roll(50) ? 32'h0 : 32'hffff_ffff) : $urandom,
				lts_pkg::TOP_COUNT_BITS'(n), shape, roll(4));
		end

		// single reset at the start
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while ((pending_cmds.size() != 0 || in_valid || expected_results.size() != 0) &&
				idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);

		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d results outstanding",
				expected_results.size());
			$display("** lifo_stack_with_multi_top_read_unit: FAILED **");
		end else begin
			// let any trailing multi-top sequence finish and catch extra results
			repeat (TAIL_CYCLES) @(posedge clk);
			if (expected_results.size() != 0)
				mismatch_count++;
			$display("covered %0d commands (%0d multi-top reads), %0d results checked",
				cmds_accepted, multi_reads, results_seen);
			$display("peak depth %0d of %0d, %0d refused pushes, %0d mismatches",
				peak_fill, lts_pkg::STACK_DEPTH, full_refusals, mismatch_count);
			if (mismatch_count == 0)
				$display("** lifo_stack_with_multi_top_read_unit: PASSED **");
			else
				$display("** lifo_stack_with_multi_top_read_unit: FAILED **");
		end
		$finish;
	end

endmodule
